FILE: rtl/key_block_sorter_unit_defines.svh
// Assertion macros for the key block sorter checker.
// Used by kbs_checker.sv; expects clk and arst_n in scope.
`ifndef KEY_BLOCK_SORTER_UNIT_DEFINES_SVH
`define KEY_BLOCK_SORTER_UNIT_DEFINES_SVH

// ante on one edge implies cons on the next edge
`define KBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kbs: next-cycle check failed");

// expr never holds
`define KBS_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("kbs: forbidden condition seen");

`endif

FILE: rtl/kbs_pkg.sv
// Package for the key block sorter: sizes, key type, chain link type.
// No dependencies.
`default_nettype none
package kbs_pkg;
	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_BITS-1:0] key_t;

	typedef struct packed {
		logic vld;
		key_t key;
	} link_t;
endpackage
`default_nettype wire

FILE: rtl/kbs_cell.sv
// One cell of the insertion chain: keeps the smaller key, passes the larger on.
// In shift mode takes the key held by the next cell. Depends on kbs_pkg.
`default_nettype none
module kbs_cell (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             shift,
	input  kbs_pkg::link_t  ins,
	input  kbs_pkg::link_t  nxt,
	output kbs_pkg::link_t  pass,
	output kbs_pkg::link_t  held
);
	kbs_pkg::key_t held_q;
	logic          hvld_q;
	kbs_pkg::key_t pass_q;
	logic          pvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvld_q <= 1'b0;
			pvld_q <= 1'b0;
		end else if (shift) begin
			hvld_q <= nxt.vld;
			pvld_q <= 1'b0;
		end else if (ins.vld) begin
			hvld_q <= 1'b1;
			pvld_q <= hvld_q;
		end else begin
			pvld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			held_q <= nxt.key;
		end else if (ins.vld) begin
			if (!hvld_q) begin
				held_q <= ins.key;
			end else if (ins.key < held_q) begin
				held_q <= ins.key;
				pass_q <= held_q;
			end else begin
				pass_q <= ins.key;
			end
		end
	end

	assign pass = '{vld: pvld_q, key: pass_q};
	assign held = '{vld: hvld_q, key: held_q};
endmodule
`default_nettype wire

FILE: rtl/key_block_sorter_unit.sv
// Top level of the key block sorter: control and a chain of kbs_cell.
// Depends on kbs_pkg and kbs_cell.
//
//  channel | signals                         | handshake
//  key     | key, block_end                  | key_valid / key_ready
//  result  | sorted_key, final_res, overflow | res_valid / res_ready
//
// Keys are taken one per cycle while the block is loading.
// After the key with block_end, the chain settles in the settle state,
// then one result per cycle (n results for n stored keys) as res_ready allows.
// No keys are taken during settle or drain.
// Reset empties the chain, the fill count and the dropped flag.
// A stalled result holds the chain still; the result stays on the ports.
`default_nettype none
module key_block_sorter_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire signed [31:0]  key,
	input  wire                block_end,
	input  wire                key_valid,
	output logic               key_ready,
	output logic signed [31:0] sorted_key,
	output logic               final_res,
	output logic               overflow,
	output logic               res_valid,
	input  wire                res_ready
);
	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_SETTLE = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;

	logic [1:0]                state_q;
	logic [kbs_pkg::CNT_W-1:0] fill_q;
	logic [kbs_pkg::CNT_W-1:0] settle_q;
	logic                      dropped_q;

	logic key_acc, res_acc, room, shift;
	kbs_pkg::link_t head;
	kbs_pkg::link_t pass_w [kbs_pkg::CAPACITY];
	kbs_pkg::link_t held_w [kbs_pkg::CAPACITY];

	assign key_ready = (state_q == ST_LOAD);
	assign res_valid = (state_q == ST_DRAIN);
	assign key_acc   = key_valid && key_ready;
	assign res_acc   = res_valid && res_ready;
	assign room      = (fill_q < kbs_pkg::CNT_W'(kbs_pkg::CAPACITY));
	assign shift     = res_acc;
	assign head      = '{vld: key_acc && room, key: kbs_pkg::KEY_BITS'(key)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			fill_q    <= '0;
			settle_q  <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (key_acc) begin
						if (room) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (block_end) begin
							state_q  <= ST_SETTLE;
							settle_q <= '0;
						end
					end
				end
				ST_SETTLE: begin
					settle_q <= settle_q + 1'b1;
					if (settle_q == kbs_pkg::CNT_W'(kbs_pkg::CAPACITY - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res_acc) begin
						fill_q <= fill_q - 1'b1;
						if (fill_q == kbs_pkg::CNT_W'(1)) begin
							state_q   <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < kbs_pkg::CAPACITY; i++) begin : g_cell
		kbs_pkg::link_t ins_w, nxt_w;
		if (i == 0) begin : g_head
			assign ins_w = head;
		end else begin : g_mid
			assign ins_w = pass_w[i-1];
		end
		if (i == kbs_pkg::CAPACITY - 1) begin : g_tail
			assign nxt_w = '0;
		end else begin : g_body
			assign nxt_w = held_w[i+1];
		end
		kbs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.ins    (ins_w),
			.nxt    (nxt_w),
			.pass   (pass_w[i]),
			.held   (held_w[i])
		);
	end

	assign sorted_key = 32'(held_w[0].key);
	assign final_res  = (fill_q == kbs_pkg::CNT_W'(1));
	assign overflow   = dropped_q;
endmodule
`default_nettype wire

FILE: rtl/kbs_checker.sv
// Port-level checker for key_block_sorter_unit, bound to the top level.
// Depends on key_block_sorter_unit_defines.svh.
`default_nettype none
`include "key_block_sorter_unit_defines.svh"
module kbs_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               key_ready,
	input wire signed [31:0] sorted_key,
	input wire               final_res,
	input wire               overflow,
	input wire               res_valid,
	input wire               res_ready
);
	logic res_acc;

	assign res_acc = res_valid && res_ready;

	`KBS_ASSERT_NEVER(a_no_load_in_drain, key_ready && res_valid)
	`KBS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(sorted_key))
	`KBS_ASSERT_NEXT(a_ascending, res_acc && !final_res, res_valid && sorted_key >= $past(sorted_key))
	`KBS_ASSERT_NEXT(a_ovf_steady, res_acc && !final_res, overflow == $past(overflow))
	`KBS_ASSERT_NEXT(a_end_of_block, res_acc && final_res, !res_valid && key_ready)
endmodule

bind key_block_sorter_unit kbs_checker u_kbs_checker (.*);
`default_nettype wire
